// ===== rtl/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants of the stepper wave drive with speed button.
// ----------------------------------------------------------------------------
package swd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PRESCALE_W  = 8;
    localparam int COUNT_W     = 16;
    localparam int PERIOD_W    = 16;
    localparam int COIL_W      = 4;
    localparam int PHASE_W     = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STEP_PRESCALE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DEBOUNCE_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PERIOD_STEP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PERIOD_MIN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PERIOD_MAX     = 3'd4;

    localparam logic [PRESCALE_W-1:0] RST_STEP_PRESCALE  = 8'd8;
    localparam logic [COUNT_W-1:0]    RST_DEBOUNCE_TICKS = 16'd4000;
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_STEP    = 16'd1000;
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_MIN     = 16'd1000;
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_MAX     = 16'd25000;

    typedef struct packed {
        logic [PRESCALE_W-1:0] step_prescale;
        logic [COUNT_W-1:0]    debounce_ticks;
        logic [PERIOD_W-1:0]   period_step;
        logic [PERIOD_W-1:0]   period_min;
        logic [PERIOD_W-1:0]   period_max;
    } cfg_t;

endpackage

// ===== rtl/swd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// swd_cfg_regs
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module swd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output swd_pkg::cfg_t                    cfg
);

    swd_pkg::cfg_t cfg_reg;
    swd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                swd_pkg::CFG_IDX_STEP_PRESCALE:
                    cfg_next.step_prescale = cfg_data[swd_pkg::PRESCALE_W-1:0];
                swd_pkg::CFG_IDX_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_data;
                swd_pkg::CFG_IDX_PERIOD_STEP:    cfg_next.period_step    = cfg_data;
                swd_pkg::CFG_IDX_PERIOD_MIN:     cfg_next.period_min     = cfg_data;
                swd_pkg::CFG_IDX_PERIOD_MAX:     cfg_next.period_max     = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_prescale  <= swd_pkg::RST_STEP_PRESCALE;
            cfg_reg.debounce_ticks <= swd_pkg::RST_DEBOUNCE_TICKS;
            cfg_reg.period_step    <= swd_pkg::RST_PERIOD_STEP;
            cfg_reg.period_min     <= swd_pkg::RST_PERIOD_MIN;
            cfg_reg.period_max     <= swd_pkg::RST_PERIOD_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/swd_period_ctrl.sv =====
// ----------------------------------------------------------------------------
// swd_period_ctrl
// Button debounce and step period adjustment.
// ----------------------------------------------------------------------------
module swd_period_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           button_level,
    input  logic                           direction_level,
    input  swd_pkg::cfg_t                  cfg,
    output logic [swd_pkg::PERIOD_W-1:0]   period_next
);

    logic                          db_active_reg;
    logic                          db_active_next;
    logic [swd_pkg::COUNT_W-1:0]   db_count_reg;
    logic [swd_pkg::COUNT_W-1:0]   db_count_next;
    logic                          last_button_reg;
    logic [swd_pkg::PERIOD_W-1:0]  period_reg;

    logic [swd_pkg::COUNT_W-1:0]   db_len;
    logic [swd_pkg::COUNT_W:0]     db_count_inc;
    logic                          db_done;
    logic [swd_pkg::PERIOD_W-1:0]  faster_val;
    logic [swd_pkg::PERIOD_W:0]    slower_sum;
    logic [swd_pkg::PERIOD_W-1:0]  slower_val;
    logic [swd_pkg::PERIOD_W-1:0]  adjusted;

    assign db_len       = (cfg.debounce_ticks == '0) ? swd_pkg::COUNT_W'(1) : cfg.debounce_ticks;
    assign db_count_inc = {1'b0, db_count_reg} + (swd_pkg::COUNT_W+1)'(1);
    assign db_done      = db_count_inc >= {1'b0, db_len};

    always_comb begin
        faster_val = (period_reg > cfg.period_step) ? period_reg - cfg.period_step : '0;
        if (faster_val < cfg.period_min) begin
            faster_val = cfg.period_min;
        end
        slower_sum = {1'b0, period_reg} + {1'b0, cfg.period_step};
        if (slower_sum > {1'b0, cfg.period_max}) begin
            slower_val = cfg.period_max;
        end else begin
            slower_val = slower_sum[swd_pkg::PERIOD_W-1:0];
        end
        adjusted = period_reg;
        if (direction_level) begin
            if (period_reg > cfg.period_min) begin
                adjusted = faster_val;
            end
        end else begin
            if (period_reg < cfg.period_max) begin
                adjusted = slower_val;
            end
        end
    end

    always_comb begin
        db_active_next = db_active_reg;
        db_count_next  = db_count_reg;
        period_next    = period_reg;
        if (db_active_reg) begin
            if (db_done) begin
                if (!button_level) begin
                    period_next = adjusted;
                end
                db_active_next = 1'b0;
                db_count_next  = '0;
            end else begin
                db_count_next = db_count_inc[swd_pkg::COUNT_W-1:0];
            end
        end else if (last_button_reg && !button_level) begin
            db_active_next = 1'b1;
            db_count_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            db_active_reg   <= 1'b0;
            db_count_reg    <= '0;
            last_button_reg <= 1'b1;
            period_reg      <= swd_pkg::RST_PERIOD_MAX;
        end else if (advance) begin
            db_active_reg   <= db_active_next;
            db_count_reg    <= db_count_next;
            last_button_reg <= button_level;
            period_reg      <= period_next;
        end
    end

endmodule

// ===== rtl/swd_step_timer.sv =====
// ----------------------------------------------------------------------------
// swd_step_timer
// Prescaler, step counter and four-phase wave drive sequencer.
// ----------------------------------------------------------------------------
module swd_step_timer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic [swd_pkg::PRESCALE_W-1:0]   step_prescale,
    input  logic [swd_pkg::PERIOD_W-1:0]     period,
    output logic [swd_pkg::COIL_W-1:0]       coil_next,
    output logic                             stepped
);

    logic [swd_pkg::PRESCALE_W-1:0] pre_count_reg;
    logic [swd_pkg::PRESCALE_W-1:0] pre_count_next;
    logic [swd_pkg::COUNT_W-1:0]    step_count_reg;
    logic [swd_pkg::COUNT_W-1:0]    step_count_next;
    logic [swd_pkg::PHASE_W-1:0]    phase_reg;
    logic [swd_pkg::PHASE_W-1:0]    phase_next;
    logic [swd_pkg::COIL_W-1:0]     coil_reg;

    logic [swd_pkg::PRESCALE_W-1:0] pre_len;
    logic [swd_pkg::PRESCALE_W:0]   pre_inc;
    logic [swd_pkg::COUNT_W:0]      step_inc;

    assign pre_len  = (step_prescale == '0) ? swd_pkg::PRESCALE_W'(1) : step_prescale;
    assign pre_inc  = {1'b0, pre_count_reg} + (swd_pkg::PRESCALE_W+1)'(1);
    assign step_inc = {1'b0, step_count_reg} + (swd_pkg::COUNT_W+1)'(1);

    always_comb begin
        pre_count_next  = pre_count_reg;
        step_count_next = step_count_reg;
        phase_next      = phase_reg;
        coil_next       = coil_reg;
        stepped         = 1'b0;
        if (pre_inc >= {1'b0, pre_len}) begin
            pre_count_next = '0;
            if (step_inc >= {1'b0, period}) begin
                step_count_next = '0;
                coil_next       = swd_pkg::COIL_W'(1) << phase_reg;
                phase_next      = phase_reg + swd_pkg::PHASE_W'(1);
                stepped         = 1'b1;
            end else begin
                step_count_next = step_inc[swd_pkg::COUNT_W-1:0];
            end
        end else begin
            pre_count_next = pre_inc[swd_pkg::PRESCALE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_count_reg  <= '0;
            step_count_reg <= '0;
            phase_reg      <= '0;
            coil_reg       <= '0;
        end else if (advance) begin
            pre_count_reg  <= pre_count_next;
            step_count_reg <= step_count_next;
            phase_reg      <= phase_next;
            coil_reg       <= coil_next;
        end
    end

endmodule

// ===== rtl/stepper_wave_drive_speed_button.sv =====
// ----------------------------------------------------------------------------
// stepper_wave_drive_speed_button
// Wave drive stepper controller with a debounced speed button.
// ----------------------------------------------------------------------------
// The result of an input transfer is registered and appears on the m_ side in the next cycle.
// Throughput: 1 item per cycle; the result register frees while m_tready is high.
// Each item passes one level of debounce, period and step logic into that register.
// Reset (aresetn low, synchronous): registers to defaults, period to 25000,
// coils off, debounce idle, button released, result register empty.
module stepper_wave_drive_speed_button (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swd_pkg::S_TDATA_W-1:0]    s_tdata,   // button_level, direction_level
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swd_pkg::M_TDATA_W-1:0]    m_tdata,   // coil_drive, current_period, step_taken
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    swd_pkg::cfg_t                 cfg;
    logic                          s_xfer;
    logic [swd_pkg::PERIOD_W-1:0]  period_next;
    logic [swd_pkg::COIL_W-1:0]    coil_next;
    logic                          stepped;
    logic                          m_valid_reg;
    logic [swd_pkg::M_TDATA_W-1:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    swd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swd_period_ctrl u_period (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (s_xfer),
        .button_level    (s_tdata[0]),
        .direction_level (s_tdata[1]),
        .cfg             (cfg),
        .period_next     (period_next)
    );

    swd_step_timer u_timer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (s_xfer),
        .step_prescale (cfg.step_prescale),
        .period        (period_next),
        .coil_next     (coil_next),
        .stepped       (stepped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= {3'b000, stepped, period_next, coil_next};
        end
    end

`ifndef SYNTHESIS
    a_xfer_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("input transfer did not produce a result");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_coil_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("coil drive not one-hot");

    a_step_drives_coil: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[20]) |-> $onehot(m_tdata[3:0]))
        else $error("step taken without an active coil");
`endif

endmodule
